>>> rtl/breath_cycle_phase_timer_core_assert.svh
// Assertion macros used by the checker of the breath cycle phase timer.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef BREATH_CYCLE_PHASE_TIMER_CORE_ASSERT_SVH
`define BREATH_CYCLE_PHASE_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BCPT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bcpt_pkg.sv
// Package of the breath cycle phase timer: widths, register indexes, reset values,
// divider constants and the result payload type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcpt_pkg;

   // Channel widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 72;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int RATIO_W    = 7;
   localparam int MS_W       = 13;

   localparam logic [CSR_ADDR_W-1:0] CSR_BPM        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IE_INHALE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_IE_EXHALE  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_IN    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEEP_PAUSE = 3'd4;

   localparam logic [RATIO_W-1:0] BPM_RESET     = 7'd12;
   localparam logic [RATIO_W-1:0] INHALE_RESET  = 7'd10;
   localparam logic [RATIO_W-1:0] EXHALE_RESET  = 7'd20;
   localparam logic [MS_W-1:0]    HOLD_RESET    = 13'd250;
   localparam logic [MS_W-1:0]    PEEP_RESET    = 13'd500;

   // Field widths.
   localparam int TIME_W  = 16;
   localparam int PRESS_W = 16;
   localparam int SHOWN_W = 17;
   localparam int INSP_W  = 18;
   localparam logic [SHOWN_W-1:0] SHOWN_MAX = 17'h1FFFF;

   // Serial divider and multiplier.
   localparam int QUO_W = 23;
   localparam int CNT_W = 5;
   localparam logic [QUO_W-1:0] RATE_DIVIDEND   = 23'd6000000;
   // 60000 moved up by seven places so that sixteen steps consume it.
   localparam logic [QUO_W-1:0] PERIOD_DIVIDEND = 23'd7680000;
   localparam logic [CNT_W-1:0] RATE_STEPS   = 5'd23;
   localparam logic [CNT_W-1:0] PERIOD_STEPS = 5'd16;
   localparam logic [CNT_W-1:0] MUL_STEPS    = 5'd7;
   localparam logic [CNT_W-1:0] INSP_STEPS   = 5'd23;

   typedef struct packed {
      logic [SHOWN_W-1:0]        elapsed_ms;
      logic [TIME_W-1:0]         resp_rate;
      logic signed [PRESS_W-1:0] last_breath_peak;
      logic signed [PRESS_W-1:0] running_peak;
      logic                      timing_error;
      logic                      peep_pause_done;
      logic                      expiration_done;
      logic                      hold_done;
      logic                      inspiration_done;
   } rsp_payload_type;

   localparam int RSP_PAYLOAD_W = $bits(rsp_payload_type);

endpackage

`default_nettype wire

>>> rtl/breath_cycle_phase_timer_core.sv
// Breath cycle phase timer core: phase lengths, rate and peak tracking of one breath.
// Depends on bcpt_pkg. Uses one shared bit-serial divider and a serial multiplier.
//
// Usage: each req transaction carries one step of the breath timer: a start-breath
// flag, a pressure sample qualified by req_tuser, and a millisecond tick. Every
// transaction yields exactly one rsp transaction with the phase-done flags, the
// error flag, the running and last peaks, the last measured rate and the elapsed
// time. Configuration must be written by the user through csr_we/csr_addr/csr_wdata
// only while idle; the core itself does not enforce this. A step without start
// passes from idle through the apply and output states into the rsp register. A
// step with start first runs the restoring divider one quotient bit per cycle for
// the rate (23 steps) and the period (16 steps), a shift-add multiplier (7 steps)
// and the inspiration division (23 steps), then the finish state, before apply and
// output. One step is in work at a time, so a new transaction is not taken until
// the previous one has reached the rsp register. req_tready is high while the core
// is idle, and a new transaction is taken even while the previous result waits in
// the rsp register. When rsp_tready is low the finished result holds until the
// register frees up. Synchronous reset clears the timing state, peaks, rate and
// elapsed count, restores the register defaults and empties the rsp register.
`timescale 1ns / 1ps
`default_nettype none

module breath_cycle_phase_timer_core #(
   parameter int ELAPSED_WIDTH = 17
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: start_breath[0], pressure_sample[16:1], tick[17], zero pad [23:18]
   input  wire logic [bcpt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: sample_valid[0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: inspiration_done[0], hold_done[1], expiration_done[2],
   // peep_pause_done[3], timing_error[4], running_peak[20:5],
   // last_breath_peak[36:21], resp_rate[52:37], elapsed_ms[69:53], zero pad [71:70]
   output logic [bcpt_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [bcpt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [bcpt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bcpt_pkg::*;

   localparam int EW   = ELAPSED_WIDTH;
   localparam int DIVW = ELAPSED_WIDTH;
   localparam int CW   = ELAPSED_WIDTH + 1;
   localparam logic [EW-1:0] ELAPSED_SHOW_MAX = EW'(SHOWN_MAX);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_RATE = 3'd1;
   localparam logic [2:0] ST_DIV_PER  = 3'd2;
   localparam logic [2:0] ST_MUL      = 3'd3;
   localparam logic [2:0] ST_DIV_INSP = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;
   localparam logic [2:0] ST_APPLY    = 3'd6;
   localparam logic [2:0] ST_OUTPUT   = 3'd7;

   logic [2:0]              state_ff,      state_in;
   logic [CNT_W-1:0]        cnt_ff,        cnt_in;
   logic [DIVW:0]           rem_ff,        rem_in;
   logic [QUO_W-1:0]        dvd_ff,        dvd_in;
   logic [QUO_W-1:0]        quo_ff,        quo_in;
   logic [DIVW-1:0]         dvs_ff,        dvs_in;
   logic [QUO_W-1:0]        acc_ff,        acc_in;
   logic [RATIO_W-1:0]      msr_ff,        msr_in;

   logic                    svalid_ff,     svalid_in;
   logic signed [PRESS_W-1:0] sample_ff,   sample_in;
   logic                    tick_ff,       tick_in;

   logic [RATIO_W-1:0]      bpm_ff,        bpm_in;
   logic [RATIO_W-1:0]      inhale_ff,     inhale_in;
   logic [RATIO_W-1:0]      exhale_ff,     exhale_in;
   logic [MS_W-1:0]         hold_ff,       hold_in;
   logic [MS_W-1:0]         peep_ff,       peep_in;

   logic [EW-1:0]           elapsed_ff,    elapsed_in;
   logic [TIME_W-1:0]       period_ff,     period_in;
   logic [TIME_W-1:0]       insp_total_ff, insp_total_in;
   logic signed [INSP_W-1:0] insp_ms_ff,   insp_ms_in;
   logic [TIME_W-1:0]       expire_ff,     expire_in;
   logic                    error_ff,      error_in;
   logic signed [PRESS_W-1:0] peak_now_ff, peak_now_in;
   logic signed [PRESS_W-1:0] peak_last_ff, peak_last_in;
   logic [TIME_W-1:0]       rate_ff,       rate_in;

   logic                    rsp_valid_ff,  rsp_valid_in;
   rsp_payload_type         rsp_data_ff,   rsp_data_in;

   // One restoring division step and one shift-add multiply step.
   logic [DIVW:0]           rem_shift;
   logic                    div_ge;
   logic [DIVW:0]           rem_step;
   logic [QUO_W-1:0]        quo_step;
   logic [QUO_W-1:0]        acc_step;
   logic                    last_step;
   logic [RATIO_W:0]        ie_sum;
   logic signed [INSP_W-1:0] insp_ms_calc;
   logic [SHOWN_W-1:0]      peep_limit;
   rsp_payload_type         result;

   assign rem_shift = {rem_ff[DIVW-1:0], dvd_ff[QUO_W-1]};
   assign div_ge    = rem_shift >= {1'b0, dvs_ff};
   assign rem_step  = div_ge ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
   assign quo_step  = {quo_ff[QUO_W-2:0], div_ge};
   assign acc_step  = {acc_ff[QUO_W-2:0], 1'b0}
                      + (msr_ff[RATIO_W-1] ? QUO_W'(period_ff) : '0);
   assign last_step = (cnt_ff == CNT_W'(1));
   assign ie_sum    = {1'b0, inhale_ff} + {1'b0, exhale_ff};

   assign insp_ms_calc = $signed({2'b00, insp_total_ff}) - $signed({5'b00000, hold_ff});
   assign peep_limit   = {1'b0, expire_ff} + {4'b0000, peep_ff};

   always_comb begin
      result.inspiration_done = insp_ms_ff[INSP_W-1]
                                | ({1'b0, elapsed_ff} > CW'(insp_ms_ff[INSP_W-2:0]));
      result.hold_done        = elapsed_ff > EW'(insp_total_ff);
      result.expiration_done  = elapsed_ff > EW'(period_ff);
      result.peep_pause_done  = elapsed_ff > EW'(peep_limit);
      result.timing_error     = error_ff;
      result.running_peak     = peak_now_ff;
      result.last_breath_peak = peak_last_ff;
      result.resp_rate        = rate_ff;
      result.elapsed_ms       = (elapsed_ff > ELAPSED_SHOW_MAX) ? SHOWN_MAX
                                                                : elapsed_ff[SHOWN_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      acc_in        = acc_ff;
      msr_in        = msr_ff;
      svalid_in     = svalid_ff;
      sample_in     = sample_ff;
      tick_in       = tick_ff;
      bpm_in        = bpm_ff;
      inhale_in     = inhale_ff;
      exhale_in     = exhale_ff;
      hold_in       = hold_ff;
      peep_in       = peep_ff;
      elapsed_in    = elapsed_ff;
      period_in     = period_ff;
      insp_total_in = insp_total_ff;
      insp_ms_in    = insp_ms_ff;
      expire_in     = expire_ff;
      error_in      = error_ff;
      peak_now_in   = peak_now_ff;
      peak_last_in  = peak_last_ff;
      rate_in       = rate_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_BPM:        bpm_in    = csr_wdata[RATIO_W-1:0];
            CSR_IE_INHALE:  inhale_in = csr_wdata[RATIO_W-1:0];
            CSR_IE_EXHALE:  exhale_in = csr_wdata[RATIO_W-1:0];
            CSR_HOLD_IN:    hold_in   = csr_wdata[MS_W-1:0];
            CSR_PEEP_PAUSE: peep_in   = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               svalid_in = req_tuser;
               sample_in = $signed(req_tdata[16:1]);
               tick_in   = req_tdata[17];
               if (req_tdata[0]) begin
                  rem_in   = '0;
                  quo_in   = '0;
                  dvd_in   = RATE_DIVIDEND;
                  dvs_in   = elapsed_ff;
                  cnt_in   = RATE_STEPS;
                  state_in = ST_DIV_RATE;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_DIV_RATE: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_step) begin
               // A zero divisor gives an all-ones quotient, which saturates too.
               rate_in  = (|quo_step[QUO_W-1:TIME_W]) ? '1 : quo_step[TIME_W-1:0];
               rem_in   = '0;
               quo_in   = '0;
               dvd_in   = PERIOD_DIVIDEND;
               dvs_in   = DIVW'(bpm_ff);
               cnt_in   = PERIOD_STEPS;
               state_in = ST_DIV_PER;
            end
         end
         ST_DIV_PER: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_step) begin
               // A zero bpm setting leaves sixteen ones, the saturated period.
               period_in = quo_step[TIME_W-1:0];
               acc_in    = '0;
               msr_in    = inhale_ff;
               cnt_in    = MUL_STEPS;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = acc_step;
            msr_in = {msr_ff[RATIO_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_step) begin
               rem_in   = '0;
               quo_in   = '0;
               dvd_in   = acc_step;
               dvs_in   = DIVW'(ie_sum);
               cnt_in   = INSP_STEPS;
               state_in = ST_DIV_INSP;
            end
         end
         ST_DIV_INSP: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (last_step) begin
               insp_total_in = (ie_sum == '0) ? '0 : quo_step[TIME_W-1:0];
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            insp_ms_in   = insp_ms_calc;
            expire_in    = (insp_total_ff <= period_ff) ? (period_ff - insp_total_ff) : '0;
            error_in     = insp_ms_calc[INSP_W-1] | (insp_total_ff > period_ff);
            peak_last_in = peak_now_ff;
            peak_now_in  = '0;
            elapsed_in   = '0;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            if (svalid_ff && (sample_ff > peak_now_ff)) begin
               peak_now_in = sample_ff;
            end
            if (tick_ff && (elapsed_ff != '1)) begin
               elapsed_in = elapsed_ff + EW'(1);
            end
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bpm_ff        <= BPM_RESET;
         inhale_ff     <= INHALE_RESET;
         exhale_ff     <= EXHALE_RESET;
         hold_ff       <= HOLD_RESET;
         peep_ff       <= PEEP_RESET;
         elapsed_ff    <= '0;
         period_ff     <= '0;
         insp_total_ff <= '0;
         insp_ms_ff    <= '0;
         expire_ff     <= '0;
         error_ff      <= 1'b0;
         peak_now_ff   <= '0;
         peak_last_ff  <= '0;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bpm_ff        <= bpm_in;
         inhale_ff     <= inhale_in;
         exhale_ff     <= exhale_in;
         hold_ff       <= hold_in;
         peep_ff       <= peep_in;
         elapsed_ff    <= elapsed_in;
         period_ff     <= period_in;
         insp_total_ff <= insp_total_in;
         insp_ms_ff    <= insp_ms_in;
         expire_ff     <= expire_in;
         error_ff      <= error_in;
         peak_now_ff   <= peak_now_in;
         peak_last_ff  <= peak_last_in;
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      acc_ff      <= acc_in;
      msr_ff      <= msr_in;
      svalid_ff   <= svalid_in;
      sample_ff   <= sample_in;
      tick_ff     <= tick_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_PAYLOAD_W)'(0), rsp_data_ff};

endmodule

`default_nettype wire

>>> rtl/bcpt_checker.sv
// Port-level checker for the breath cycle phase timer core, bound to the core module.
// Depends on bcpt_pkg and breath_cycle_phase_timer_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "breath_cycle_phase_timer_core_assert.svh"

module bcpt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [bcpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready
);
   import bcpt_pkg::*;

   rsp_payload_type payload;

   assign payload = rsp_payload_type'(rsp_tdata[RSP_PAYLOAD_W-1:0]);

   // A stalled result must stay put until the receiver takes it.
   `BCPT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp transaction changed while stalled")

   // Only one step is in work, so the input closes right after a transaction.
   `BCPT_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second req transaction taken while busy")

   // The running peak restarts from zero at each breath start and only rises in between.
   `BCPT_ASSERT_SAME(a_peak_nonneg, rsp_tvalid, !payload.running_peak[PRESS_W-1], "running peak went negative")

   // Hold time never shortens inspiration; an error flags inspiration < 0 or > period.
   `BCPT_ASSERT_SAME(a_phase_order, rsp_tvalid && (payload.hold_done || payload.timing_error), payload.inspiration_done, "inspiration flag inconsistent with hold or error")

endmodule

bind breath_cycle_phase_timer_core bcpt_checker u_bcpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
